### sv/plt_pkg.sv
// Package for the positional list engine: sizes, command and status codes, cell control type.
package plt_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W = 5;
    localparam int LEN_W = 5;

    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Broadcast to every cell of the chain for one command.
    typedef struct packed {
        logic               ins;
        logic               del;
        logic [IDX_W-1:0]   pos_idx;
        logic [DATA_W-1:0]  value;
    } cell_ctrl_t;

endpackage

### sv/plt_cell.sv
// One storage cell of the list chain; shifts with its neighbors on insert and delete.
module plt_cell
    import plt_pkg::*;
(
    input  logic                clk,
    input  cell_ctrl_t          ctrl,
    input  logic [IDX_W-1:0]    idx,
    input  logic [DATA_W-1:0]   left_in,
    input  logic [DATA_W-1:0]   right_in,
    output logic [DATA_W-1:0]   q
);

    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] q_next;

    // On insert, the target cell takes the new value and later cells take the
    // element before them. On delete, the target and later cells take the
    // element after them.
    always_comb
    begin
        q_next = q_reg;
        if (ctrl.ins)
        begin
            if (idx == ctrl.pos_idx)
            begin
                q_next = ctrl.value;
            end
            else if (idx > ctrl.pos_idx)
            begin
                q_next = left_in;
            end
        end
        else if (ctrl.del)
        begin
            if (idx >= ctrl.pos_idx)
            begin
                q_next = right_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

### sv/positional_list_engine.sv
// Top level of the positional list engine: command decode, count and result registers, cell chain.
//
//  Channel   Direction  Handshake            Ports
//  command   in         start & !busy        cmd, position, value
//  result    out        done (one cycle)     status, data, length
//
// Each command is transferred at the rising clock edge where
// start is high and busy is low, and its result is on the result ports,
// marked by done, during the very next cycle. The chain of cells moves all
// elements in parallel, so busy stays low and a command can be transferred
// every cycle. Reset (rst_n low, asynchronous) empties the list and clears
// done; the element storage itself is not cleared, since only positions
// below the length are ever read. The receiver cannot stall the result.
module positional_list_engine
    import plt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          cmd,
    input  logic [POS_W-1:0]    position,
    input  logic [DATA_W-1:0]   value,
    output logic                done,
    output logic [1:0]          status,
    output logic [DATA_W-1:0]   data,
    output logic [LEN_W-1:0]    length
);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               done_reg;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic [DATA_W-1:0]  data_reg;
    logic [DATA_W-1:0]  data_next;

    logic               accept;
    logic [31:0]        pos32;
    logic [31:0]        cnt32;
    logic [IDX_W-1:0]   pos_idx;
    logic               pos_in_list;
    logic               pos_insertable;
    logic               full;
    cell_ctrl_t         ctrl;

    logic [DATA_W-1:0]  cell_q [DEPTH];

    // The chain handles every command without stalling.
    assign busy = 1'b0;
    assign accept = start && !busy;

    assign pos32 = 32'(position);
    assign cnt32 = 32'(count_reg);
    // Index of the addressed slot; only meaningful when the position checks pass.
    assign pos_idx = IDX_W'(pos32 - 32'd1);
    assign pos_in_list = (pos32 >= 32'd1) && (pos32 <= cnt32);
    assign pos_insertable = (pos32 >= 32'd1) && (pos32 <= cnt32 + 32'd1);
    assign full = (cnt32 >= 32'(DEPTH));

    // Decode the command into a status, the data to return, the new count,
    // and the shift control that goes to every cell.
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        data_next   = '0;
        ctrl.ins     = 1'b0;
        ctrl.del     = 1'b0;
        ctrl.pos_idx = pos_idx;
        ctrl.value   = value;
        if (accept)
        begin
            case (cmd)
                CMD_READ:
                begin
                    if (!pos_in_list)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        data_next = cell_q[pos_idx];
                    end
                end
                CMD_INSERT:
                begin
                    // A bad position is reported ahead of a full list.
                    if (!pos_insertable)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_DELETE:
                begin
                    if (!pos_in_list)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        data_next  = cell_q[pos_idx];
                        ctrl.del   = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // The chain: each cell sees its left neighbor for inserts and its right
    // neighbor for deletes. The ends are tied off; their values never land in
    // a slot that is later read.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;
            if (g == 0)
            begin : g_first
                assign left_d = value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_q[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_q[g+1];
            end
            plt_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .idx      (IDX_W'(g)),
                .left_in  (left_d),
                .right_in (right_d),
                .q        (cell_q[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Result payload needs no reset; it is qualified by done.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign data   = data_reg;
    // The length port shows the count modulo 32.
    assign length = LEN_W'(32'(count_reg));

    // Every transferred command yields its result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("command transfer not followed by a result");

    // The count never exceeds the capacity of the chain.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above capacity");

    // A full-list status is only given while the list really is full.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (count_reg == CNT_W'(DEPTH)))
        else $error("full status with list not full");

    // A clear leaves an empty list and always succeeds.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_CLEAR) |=> (length == '0 && status == ST_OK))
        else $error("clear did not empty the list");

    // A rejected command leaves the count unchanged.
    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status_next != ST_OK) |=> (count_reg == $past(count_reg)))
        else $error("rejected command changed the list length");

endmodule
